>>> src/rek_pkg.sv
// Shared types and constants for the rotary encoder key event classifier.
// Holds the transfer payload structs, register indexes, key codes and filter states.
// No dependencies.
`default_nettype none

package rek_pkg;

  typedef struct packed {
    logic        op;
    logic        data_line_high;
    logic [31:0] edge_time_us;
    logic        button_down;
    logic [31:0] scan_time_ms;
  } rek_in_t;

  typedef struct packed {
    logic signed [15:0] position_delta;
    logic [1:0]         left_key;
    logic [1:0]         right_key;
    logic               any_key;
    logic [31:0]        accepted_edges;
    logic [1:0]         scan_state;
    logic               scan_ran;
  } rek_out_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } rek_cfg_wr_t;

  localparam logic [CfgIdxW-1:0] CfgDebounce   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScanPeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongPress  = 2'd2;

  localparam logic [15:0] DebounceRst   = 16'd500;
  localparam logic [7:0]  ScanPeriodRst = 8'd5;
  localparam logic [7:0]  LongPressRst  = 8'd200;

  localparam logic OpEdge = 1'b0;
  localparam logic OpScan = 1'b1;

  localparam logic signed [15:0] PosMin = 16'sh8000;
  localparam logic signed [15:0] PosMax = 16'sh7fff;

  typedef enum logic [1:0] {
    KeyRelease = 2'd0,
    KeyClick   = 2'd1,
    KeyPress   = 2'd2
  } rek_key_e;

  typedef enum logic [3:0] {
    FsIdle     = 4'b0001,
    FsLeft     = 4'b0010,
    FsRight    = 4'b0100,
    FsReleased = 4'b1000
  } rek_filt_e;

  localparam logic [1:0] ScanCodeIdle     = 2'd0;
  localparam logic [1:0] ScanCodeLeft     = 2'd1;
  localparam logic [1:0] ScanCodeRight    = 2'd2;
  localparam logic [1:0] ScanCodeReleased = 2'd3;

endpackage

`default_nettype wire

>>> src/rek_core.sv
// Configuration registers, edge debounce, position counter and key scan filter.
// Computes the result of the held item and updates state on each advance.
// Depends on rek_pkg.
`default_nettype none

module rek_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rek_pkg::rek_cfg_wr_t cfg_wr_i,
  input  wire                  step_i,
  input  rek_pkg::rek_in_t     item_i,
  output rek_pkg::rek_out_t    res_o
);
  import rek_pkg::*;

  logic [15:0]        debounce_q;
  logic [7:0]         period_q;
  logic [7:0]         long_q;

  logic signed [15:0] pos_q, pos_d;
  logic [31:0]        last_edge_q, last_edge_d;
  logic [31:0]        total_q, total_d;
  logic [31:0]        last_scan_q, last_scan_d;
  logic [7:0]         hold_q, hold_d;
  logic               locked_q, locked_d;
  rek_filt_e          filt_q, filt_d;
  rek_key_e           left_q, left_d;
  rek_key_e           right_q, right_d;

  logic [31:0] edge_diff, scan_diff;
  logic [7:0]  hold_inc;
  logic        go_left, go_right, present, ran;
  logic [1:0]  scan_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      period_q   <= ScanPeriodRst;
      long_q     <= LongPressRst;
    end else if (cfg_wr_i.we) begin
      if (cfg_wr_i.index == CfgDebounce) begin
        debounce_q <= cfg_wr_i.data;
      end
      if (cfg_wr_i.index == CfgScanPeriod) begin
        period_q <= cfg_wr_i.data[7:0];
      end
      if (cfg_wr_i.index == CfgLongPress) begin
        long_q <= cfg_wr_i.data[7:0];
      end
    end
  end

  assign edge_diff = item_i.edge_time_us - last_edge_q;
  assign scan_diff = item_i.scan_time_ms - last_scan_q;
  assign hold_inc  = hold_q + 8'd1;
  assign go_left   = pos_q[15];
  assign go_right  = !pos_q[15] && (pos_q != 16'sd0);
  assign present   = go_left || go_right || item_i.button_down;

  always_comb begin
    pos_d       = pos_q;
    last_edge_d = last_edge_q;
    total_d     = total_q;
    last_scan_d = last_scan_q;
    hold_d      = hold_q;
    locked_d    = locked_q;
    filt_d      = filt_q;
    left_d      = left_q;
    right_d     = right_q;
    ran         = 1'b0;
    if (item_i.op == OpEdge) begin
      if (edge_diff >= {16'd0, debounce_q}) begin
        last_edge_d = item_i.edge_time_us;
        total_d     = total_q + 32'd1;
        if (item_i.data_line_high) begin
          if (pos_q != PosMin) begin
            pos_d = pos_q - 16'sd1;
          end
        end else if (pos_q != PosMax) begin
          pos_d = pos_q + 16'sd1;
        end
      end
    end else if (scan_diff >= {24'd0, period_q}) begin
      ran         = 1'b1;
      last_scan_d = item_i.scan_time_ms;
      unique case (filt_q)
        FsIdle: begin
          if (present) begin
            filt_d   = go_left ? FsLeft : FsRight;
            locked_d = 1'b1;
            pos_d    = 16'sd0;
          end
          hold_d = 8'd0;
        end
        FsLeft, FsRight: begin
          if (present) begin
            locked_d = 1'b1;
            hold_d   = hold_inc;
            if (hold_inc > long_q) begin
              left_d   = (filt_q == FsLeft) ? KeyPress : KeyRelease;
              right_d  = (filt_q == FsLeft) ? KeyRelease : KeyPress;
              hold_d   = 8'd0;
              locked_d = 1'b0;
              pos_d    = 16'sd0;
              filt_d   = FsReleased;
            end
          end else if (locked_q) begin
            left_d  = (filt_q == FsLeft) ? KeyClick : KeyRelease;
            right_d = (filt_q == FsLeft) ? KeyRelease : KeyClick;
            pos_d   = 16'sd0;
            filt_d  = FsReleased;
          end else begin
            filt_d  = FsIdle;
            left_d  = KeyRelease;
            right_d = KeyRelease;
          end
        end
        FsReleased: begin
          if (!present) begin
            filt_d = FsIdle;
            pos_d  = 16'sd0;
          end
        end
        default: begin
          filt_d = FsIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 16'sd0;
      last_edge_q <= 32'd0;
      total_q     <= 32'd0;
      last_scan_q <= 32'd0;
      hold_q      <= 8'd0;
      locked_q    <= 1'b0;
      filt_q      <= FsIdle;
      left_q      <= KeyRelease;
      right_q     <= KeyRelease;
    end else if (step_i) begin
      pos_q       <= pos_d;
      last_edge_q <= last_edge_d;
      total_q     <= total_d;
      last_scan_q <= last_scan_d;
      hold_q      <= hold_d;
      locked_q    <= locked_d;
      filt_q      <= filt_d;
      left_q      <= left_d;
      right_q     <= right_d;
    end
  end

  always_comb begin
    unique case (filt_d)
      FsIdle:     scan_code = ScanCodeIdle;
      FsLeft:     scan_code = ScanCodeLeft;
      FsRight:    scan_code = ScanCodeRight;
      FsReleased: scan_code = ScanCodeReleased;
      default:    scan_code = ScanCodeIdle;
    endcase
  end

  assign res_o.position_delta = pos_d;
  assign res_o.left_key       = left_d;
  assign res_o.right_key      = right_d;
  assign res_o.any_key        = (left_d != KeyRelease) || (right_d != KeyRelease);
  assign res_o.accepted_edges = total_d;
  assign res_o.scan_state     = scan_code;
  assign res_o.scan_ran       = ran;

endmodule

`default_nettype wire

>>> src/rotary_encoder_key_event_classifier.sv
// Top level: input register, classifier core and result register.
// Depends on rek_pkg and rek_core.
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid_i/in_stall_o   rek_in_t
//   out_*        out        out_valid_o/out_stall_i rek_out_t
//   cfg_*        in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle unless the input side stalls; each transfer passes through the input
// register, then the result register fed by the core's single pass.
// State updates as an item moves from the input register to the result register.
// Asynchronous reset restores state, settings and valid flags, but not item data.
// A stalled result holds the result register and any item in the input register;
// the input side stalls only when both are full.
`default_nettype none

module rotary_encoder_key_event_classifier (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  rek_pkg::rek_in_t                in_item_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output rek_pkg::rek_out_t               out_item_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [rek_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire [rek_pkg::CfgDataW-1:0]     cfg_data_i
);
  import rek_pkg::*;

  rek_in_t     item_q;
  logic        item_vld_q;
  rek_out_t    res_q;
  logic        res_vld_q;
  rek_out_t    core_res;
  rek_cfg_wr_t cfg_wr;
  logic        advance;
  logic        in_xfer;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.we    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign advance    = item_vld_q && !(res_vld_q && out_stall_i);
  assign in_stall_o = item_vld_q && res_vld_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  rek_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .step_i   (advance),
    .item_i   (item_q),
    .res_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_xfer) begin
      item_vld_q <= 1'b1;
    end else if (advance) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;

endmodule

`default_nettype wire

>>> test/rek_scoreboard_pkg.sv
// Scoreboard for the rotary encoder key event classifier testbench.
// Predicts the status transfer each input transfer causes and checks the block's output.
// Depends on rek_pkg.
`timescale 1ns / 100ps

package rek_tb_pkg;
  import rek_pkg::*;

  class key_event_scoreboard;
    logic [15:0]        debounce_us;
    logic [7:0]         scan_period_ms;
    logic [7:0]         long_press_scans;
    logic signed [15:0] position;
    logic [31:0]        last_edge_us;
    logic [31:0]        edge_count;
    logic [31:0]        last_scan_ms;
    logic [7:0]         hold_scans;
    logic               locked;
    logic [1:0]         filter_code;
    rek_key_e           left_key;
    rek_key_e           right_key;
    rek_out_t           pending_status[$];
    int unsigned        mismatches;
    int unsigned        scans_run;
    int unsigned        clicks;
    int unsigned        long_presses;

    function new();
      debounce_us      = DebounceRst;
      scan_period_ms   = ScanPeriodRst;
      long_press_scans = LongPressRst;
      position         = '0;
      last_edge_us     = '0;
      edge_count       = '0;
      last_scan_ms     = '0;
      hold_scans       = '0;
      locked           = 1'b0;
      filter_code      = ScanCodeIdle;
      left_key         = KeyRelease;
      right_key        = KeyRelease;
      mismatches       = 0;
      scans_run        = 0;
      clicks           = 0;
      long_presses     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
      case (index)
        CfgDebounce:   debounce_us = data;
        CfgScanPeriod: scan_period_ms = data[7:0];
        CfgLongPress:  long_press_scans = data[7:0];
        default: ;
      endcase
    endfunction

    function void set_keys(logic on_left, rek_key_e code);
      if (on_left) begin
        left_key  = code;
        right_key = KeyRelease;
      end else begin
        left_key  = KeyRelease;
        right_key = code;
      end
    endfunction

    function void note_input(rek_in_t item);
      logic [31:0] gap;
      logic        ran;
      logic        to_left;
      logic        to_right;
      logic        present;
      rek_out_t    status;
      ran = 1'b0;
      if (item.op == OpEdge) begin
        gap = item.edge_time_us - last_edge_us;
        if (gap >= 32'(debounce_us)) begin
          last_edge_us = item.edge_time_us;
          edge_count++;
          if (item.data_line_high) begin
            if (position != PosMin) position--;
          end else if (position != PosMax) begin
            position++;
          end
        end
      end else begin
        gap = item.scan_time_ms - last_scan_ms;
        if (gap >= 32'(scan_period_ms)) begin
          ran = 1'b1;
          scans_run++;
          last_scan_ms = item.scan_time_ms;
          to_left  = position < 0;
          to_right = position > 0;
          present  = to_left || to_right || item.button_down;
          case (filter_code)
            ScanCodeIdle: begin
              if (present) begin
                filter_code = to_left ? ScanCodeLeft : ScanCodeRight;
                locked      = 1'b1;
                position    = '0;
              end
              hold_scans = '0;
            end
            ScanCodeLeft, ScanCodeRight: begin
              if (present) begin
                locked = 1'b1;
                hold_scans++;
                if (hold_scans > long_press_scans) begin
                  set_keys(filter_code == ScanCodeLeft, KeyPress);
                  long_presses++;
                  hold_scans  = '0;
                  locked      = 1'b0;
                  position    = '0;
                  filter_code = ScanCodeReleased;
                end
              end else if (locked) begin
                set_keys(filter_code == ScanCodeLeft, KeyClick);
                clicks++;
                position    = '0;
                filter_code = ScanCodeReleased;
              end else begin
                filter_code = ScanCodeIdle;
                left_key    = KeyRelease;
                right_key   = KeyRelease;
              end
            end
            default: begin
              if (!present) begin
                filter_code = ScanCodeIdle;
                position    = '0;
              end
            end
          endcase
        end
      end
      status.position_delta = position;
      status.left_key       = left_key;
      status.right_key      = right_key;
      status.any_key        = (left_key != KeyRelease) || (right_key != KeyRelease);
      status.accepted_edges = edge_count;
      status.scan_state     = filter_code;
      status.scan_ran       = ran;
      pending_status.push_back(status);
    endfunction

    function void check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rek_out_t got);
      rek_out_t want;
      if (pending_status.size() == 0) begin
        $error("status transfer with no prediction waiting");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      check_field("position_delta", 33'(want.position_delta), 33'(got.position_delta));
      check_field("left_key", 33'(want.left_key), 33'(got.left_key));
      check_field("right_key", 33'(want.right_key), 33'(got.right_key));
      check_field("any_key", 33'(want.any_key), 33'(got.any_key));
      check_field("accepted_edges", 33'(want.accepted_edges), 33'(got.accepted_edges));
      check_field("scan_state", 33'(want.scan_state), 33'(got.scan_state));
      check_field("scan_ran", 33'(want.scan_ran), 33'(got.scan_ran));
    endfunction
  endclass

endpackage

>>> test/testbench.sv
// Top of the rotary encoder key event classifier testbench: clock, reset, drivers and run.
// Depends on rek_pkg, rek_tb_pkg and the rotary_encoder_key_event_classifier RTL.
`timescale 1ns / 100ps

module testbench;
  import rek_pkg::*;
  import rek_tb_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  rek_in_t             in_item = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rek_out_t            out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  logic [31:0] now_us = '0;
  logic [31:0] now_ms = '0;
  key_event_scoreboard sb;

  always #10 clk = ~clk;

  rotary_encoder_key_event_classifier uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (in_valid && !in_stall) sb.note_input(in_item);
    end
  end

  task automatic push_item(input rek_in_t item);
    in_item  <= item;
    in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    items_sent++;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_edge(input logic data_high, input logic [31:0] stamp);
    rek_in_t item;
    item.op             = OpEdge;
    item.data_line_high = data_high;
    item.edge_time_us   = stamp;
    item.button_down    = 1'($urandom_range(1));
    item.scan_time_ms   = $urandom;
    now_us = stamp;
    push_item(item);
  endtask

  task automatic send_scan(input logic button, input logic [31:0] stamp);
    rek_in_t item;
    item.op             = OpScan;
    item.data_line_high = 1'($urandom_range(1));
    item.edge_time_us   = $urandom;
    item.button_down    = button;
    item.scan_time_ms   = stamp;
    now_ms = stamp;
    push_item(item);
  endtask

  function automatic logic [31:0] edge_gap();
    if ($urandom_range(19) == 0) return $urandom;
    if (sb.debounce_us != 0 && $urandom_range(9) == 0)
      return $urandom_range(32'(sb.debounce_us) - 1);
    return 32'(sb.debounce_us) + $urandom_range(2);
  endfunction

  function automatic logic [31:0] scan_gap();
    if ($urandom_range(19) == 0) return $urandom;
    if (sb.scan_period_ms != 0 && $urandom_range(9) == 0)
      return $urandom_range(32'(sb.scan_period_ms) - 1);
    return 32'(sb.scan_period_ms) + $urandom_range(2);
  endfunction

  // hold until every prediction has been matched and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  task automatic configure(input logic [15:0] debounce, input logic [7:0] period,
                           input logic [7:0] long_press);
    drain();
    cfg_write(CfgDebounce, debounce);
    cfg_write(CfgScanPeriod, {8'($urandom_range(255)), period});
    cfg_write(CfgLongPress, {8'($urandom_range(255)), long_press});
    cfg_write(CfgUnused, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_gestures(input int unsigned count);
    int unsigned stop_at;
    int unsigned mode;
    int unsigned hold;
    logic        turn_left;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1) == 0) send_edge(1'($urandom_range(1)), $urandom);
          else send_scan(1'($urandom_range(1)), $urandom);
        end
      end else begin
        mode      = $urandom_range(2);
        turn_left = (mode == 1);
        if (mode != 0) begin
          repeat ($urandom_range(1, 3)) send_edge(turn_left, now_us + edge_gap());
        end
        if ($urandom_range(3) == 0) hold = sb.long_press_scans + $urandom_range(1, 2);
        else hold = $urandom_range(3);
        repeat (hold + 1) begin
          if (mode != 0 && $urandom_range(4) != 0) send_edge(turn_left, now_us + edge_gap());
          send_scan(mode == 0 || $urandom_range(7) == 0, now_ms + scan_gap());
        end
        repeat ($urandom_range(1, 3)) send_scan(1'b0, now_ms + scan_gap());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_edge(1'b1, 32'd0);
    send_edge(1'b1, 32'd499);
    send_edge(1'b1, 32'd500);
    send_edge(1'b0, 32'd999);
    send_edge(1'b0, 32'd1000);
    send_edge(1'b1, 32'd1500);
    send_scan(1'b0, 32'd4);
    send_scan(1'b0, 32'd5);
    send_edge(1'b1, 32'd2000);
    send_scan(1'b0, 32'd10);
    send_scan(1'b0, 32'd15);
    send_scan(1'b1, 32'd20);
    send_scan(1'b0, 32'd25);
    send_edge(1'b0, 32'd2500);
    send_scan(1'b0, 32'd30);
    send_scan(1'b0, 32'd35);
    send_scan(1'b0, 32'd40);
    send_scan(1'b1, 32'd45);
    send_scan(1'b1, 32'd50);
    send_scan(1'b0, 32'd55);
    send_edge(1'b0, 32'hFFFF_FFFF);
    send_edge(1'b1, 32'h0000_01F2);
    send_edge(1'b1, 32'h0000_01F3);
    send_scan(1'b0, 32'hFFFF_FFFF);
    send_scan(1'b0, 32'd3);
    send_scan(1'b0, 32'd4);

    configure(16'd0, 8'd0, 8'd1);
    run_gestures(200);

    configure(16'hFFFF, 8'hFF, 8'd254);
    idle_pct = 86;
    run_gestures(200);

    configure(16'($urandom_range(1, 3000)), 8'($urandom_range(1, 30)),
              8'($urandom_range(1, 12)));
    idle_pct  = 0;
    stall_pct = 86;
    run_gestures(200);

    configure(DebounceRst, ScanPeriodRst, 8'($urandom_range(1, 6)));
    idle_pct  = 34;
    stall_pct = 34;
    run_gestures(200);

    drain();
    $display("Sent %0d transfers over %0d register settings, with wrapping timestamps;",
             items_sent, settings_used);
    $display("%0d scans ran, giving %0d clicks and %0d long presses.",
             sb.scans_run, sb.clicks, sb.long_presses);
    if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rek_pkg.sv
src/rek_core.sv
src/rotary_encoder_key_event_classifier.sv
test/rek_scoreboard_pkg.sv
test/testbench.sv
